FILE: rtl/tti_pkg.sv
`default_nettype none

package tti_pkg;

    localparam int MAX_ROWS     = 1024;
    localparam int MAX_CHANNELS = 8;

    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CH_W     = $clog2(MAX_CHANNELS);
    localparam int VADDR_W  = ROW_W + CH_W;
    localparam int ROWCNT_W = 11;
    localparam int CHCNT_W  = 4;
    localparam int COL_W    = 4;
    localparam int TIME_W   = 48;
    localparam int VAL_W    = 32;
    localparam int WGT_W    = 32;
    localparam int STAT_W   = 3;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 11;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_INC    = 3'd1,
        ST_BAD_INDEX  = 3'd2,
        ST_HALT_BELOW = 3'd3,
        ST_HALT_ABOVE = 3'd4
    } status_t;

    localparam logic [CIDX_W-1:0] CFG_ROW_COUNT     = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CHANNEL_COUNT = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_LINEAR_MODE   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_PAD_ZEROES    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_BAILOUT_MODE  = 3'd4;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // divider handshake
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/tti_if.sv
`default_nettype none

interface tti_item_if;
    import tti_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [ROW_W-1:0]         row_index;
    logic [COL_W-1:0]         column_index;
    logic signed [TIME_W-1:0] cell_value;
    logic signed [TIME_W-1:0] query_time;

    modport source (output valid, kind, row_index, column_index, cell_value, query_time,
                    input ready);
    modport sink   (input valid, kind, row_index, column_index, cell_value, query_time,
                    output ready);
endinterface

interface tti_result_if;
    import tti_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [COL_W-1:0]        channel_number;
    logic signed [VAL_W-1:0] channel_value;
    logic [STAT_W-1:0]       status;
    logic                    last_of_run;

    modport source (output valid, channel_number, channel_value, status, last_of_run,
                    input ready);
    modport sink   (input valid, channel_number, channel_value, status, last_of_run,
                    output ready);
endinterface

interface tti_cfg_if;
    import tti_pkg::*;
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tti_ram.sv
`default_nettype none

module tti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: rtl/tti_div.sv
`default_nettype none

// Restoring divider, one quotient bit a cycle: quo = floor(2^WGT_W * num / den), num < den.
module tti_div
    import tti_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [TIME_W-1:0] num,
    input  wire logic [TIME_W-1:0] den,
    output logic      [WGT_W-1:0]  quo,
    output div_stat_t              stat
);

    localparam int REM_W = TIME_W + 2;
    localparam int CNT_W = $clog2(WGT_W + 1);

    logic [REM_W-1:0]  rem_reg;
    logic [TIME_W-1:0] den_reg;
    logic [WGT_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W-1:0]  rem_sh;

    assign rem_sh = {rem_reg[REM_W-2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= REM_W'(num);
                den_reg  <= den;
                quo_reg  <= '0;
                cnt_reg  <= CNT_W'(WGT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (rem_sh >= REM_W'(den_reg))
                begin
                    rem_reg <= rem_sh - REM_W'(den_reg);
                    quo_reg <= {quo_reg[WGT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[WGT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/time_table_interpolator_core.sv
`default_nettype none

// Piecewise-linear (or, with linear mode off, stepwise) table interpolator. Load words write
// one cell of the table (a row time or one channel value; a bad index writes nothing) and
// return a single acknowledgement word. A row-time load reads the time of the row before to
// check it, a channel-value load writes directly, and a bad index is answered from idle.
// A query word returns one word per channel (or a single halt word). A query first reads the
// first and last row times for the end checks. A query at or beyond a table end then reads
// each channel's end-row value in turn, or goes straight to its halt word. Inside the table
// it walks the index down and up from the remembered row, fetches the bracketing times and
// runs the serial divider (linear mode, strictly inside a row only). It then reads each
// channel's values and, when interpolating, multiplies before offering the channel's word.
// The pace is set by the one-bit-a-cycle divider, the single shared multiplier and the
// single port of each table memory. The block takes no new word until the last result of
// the current one has been taken.
// Configuration writes are accepted at any time (ready is tied high).
module time_table_interpolator_core
    import tti_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    tti_cfg_if.sink      cfg,
    tti_item_if.sink     item,
    tti_result_if.source result
);

    typedef enum logic [4:0] {
        S_IDLE, S_LPREV, S_LCHK, S_LWR,
        S_Q0, S_Q1, S_Q2, S_ERD, S_EOUT,
        S_DN_RD, S_DN, S_UP_RD, S_UP,
        S_T1, S_T2, S_T3, S_DIV,
        S_V1RD, S_V2RD, S_MA, S_MB, S_MC, S_SUM,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_V1, SEL_V2, SEL_LERP
    } sel_t;

    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = DIFF_W + 17;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RES_W  = ACC_W - 15;
    localparam int DT_W   = TIME_W + 1;

    // ---------------- registers
    state_t                   state_reg, state_next;
    logic [ROWCNT_W-1:0]      rowcnt_reg, rowcnt_next;
    logic [CHCNT_W-1:0]       chcnt_reg, chcnt_next;
    logic                     linear_reg, linear_next;
    logic                     pad_reg, pad_next;
    logic [1:0]               bail_reg, bail_next;

    logic [ROW_W-1:0]         row_reg, row_next;
    logic [COL_W-1:0]         col_reg, col_next;
    logic signed [TIME_W-1:0] cval_reg, cval_next;
    logic signed [TIME_W-1:0] qt_reg, qt_next;

    logic [ROW_W-1:0]         cur_reg, cur_next;     // remembered bracketing row
    logic [ROW_W-1:0]         walk_reg, walk_next;
    logic [ROW_W-1:0]         endrow_reg, endrow_next;
    logic                     endmode_reg, endmode_next;
    logic [CH_W-1:0]          ch_reg, ch_next;
    logic signed [TIME_W-1:0] tfirst_reg, tfirst_next;
    logic signed [TIME_W-1:0] t1_reg, t1_next;
    sel_t                     sel_reg, sel_next;
    logic signed [VAL_W-1:0]  v1_reg, v1_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [PROD_W-1:0] phi_reg, phi_next;
    logic signed [PROD_W-1:0] plo_reg, plo_next;

    logic                     out_valid_reg, out_valid_next;
    logic [COL_W-1:0]         out_ch_reg, out_ch_next;
    logic signed [VAL_W-1:0]  out_val_reg, out_val_next;
    status_t                  out_st_reg, out_st_next;
    logic                     out_last_reg, out_last_next;

    // ---------------- memories
    logic                t_we, v_we;
    logic [ROW_W-1:0]    t_addr;
    logic [VADDR_W-1:0]  v_addr;
    logic [TIME_W-1:0]   t_rdata;
    logic [VAL_W-1:0]    v_rdata;

    tti_ram #(.WIDTH(TIME_W), .DEPTH(MAX_ROWS)) u_time_ram (
        .clk   (clk),
        .we    (t_we),
        .addr  (t_addr),
        .wdata (cval_reg),
        .rdata (t_rdata)
    );

    tti_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS * MAX_CHANNELS)) u_value_ram (
        .clk   (clk),
        .we    (v_we),
        .addr  (v_addr),
        .wdata (cval_reg[VAL_W-1:0]),
        .rdata (v_rdata)
    );

    // ---------------- divider
    logic              div_start;
    logic [TIME_W-1:0] div_num, div_den;
    logic [WGT_W-1:0]  wgt;
    div_stat_t         div_stat;

    tti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (wgt),
        .stat  (div_stat)
    );

    // ---------------- derived values
    logic [ROWCNT_W-1:0]      nrows;
    logic [CHCNT_W-1:0]       nch;
    logic [ROW_W-1:0]         last_row, top_row;
    logic signed [TIME_W-1:0] trd;
    logic signed [DT_W-1:0]   dt, at;
    logic [15:0]              mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;
    logic signed [RES_W-1:0]  res;
    logic signed [VAL_W-1:0]  res_sat;
    logic                     below, halt_lo, halt_hi;
    logic                     last_ch;

    always_comb
    begin
        if (rowcnt_reg == '0)
            nrows = ROWCNT_W'(1);
        else if (rowcnt_reg > ROWCNT_W'(MAX_ROWS))
            nrows = ROWCNT_W'(MAX_ROWS);
        else
            nrows = rowcnt_reg;
        if (chcnt_reg == '0)
            nch = CHCNT_W'(1);
        else if (chcnt_reg > CHCNT_W'(MAX_CHANNELS))
            nch = CHCNT_W'(MAX_CHANNELS);
        else
            nch = chcnt_reg;
    end

    assign last_row = ROW_W'(nrows - ROWCNT_W'(1));
    assign top_row  = ROW_W'(nrows - ROWCNT_W'(2));
    assign trd      = $signed(t_rdata);
    assign dt       = DT_W'(trd) - DT_W'(t1_reg);
    assign at       = DT_W'(qt_reg) - DT_W'(t1_reg);
    assign div_num  = TIME_W'(at);
    assign div_den  = TIME_W'(dt);
    assign last_ch  = (COL_W'(ch_reg) + COL_W'(1)) == nch;

    assign below   = qt_reg <= tfirst_reg;
    assign halt_lo = (qt_reg < tfirst_reg) && bail_reg[0];
    assign halt_hi = (qt_reg > trd) && bail_reg[1];

    // shared multiplier: high half of the weight, then low half
    assign mul_b = (state_reg == S_MB) ? wgt[WGT_W-1:16] : wgt[15:0];
    assign prod  = PROD_W'(diff_reg) * PROD_W'($signed({1'b0, mul_b}));

    // v1 + floor((phi + floor(plo / 2^16)) / 2^16), saturated
    assign acc = ACC_W'(phi_reg) + ACC_W'(plo_reg >>> 16);
    assign res = RES_W'(acc >>> 16) + RES_W'(v1_reg);
    always_comb
    begin
        if (res > RES_W'(32'sh7FFF_FFFF))
            res_sat = 32'sh7FFF_FFFF;
        else if (res < -(RES_W'(32'sh7FFF_FFFF)) - RES_W'(1))
            res_sat = 32'sh8000_0000;
        else
            res_sat = VAL_W'(res);
    end

    // ---------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        rowcnt_next    = rowcnt_reg;
        chcnt_next     = chcnt_reg;
        linear_next    = linear_reg;
        pad_next       = pad_reg;
        bail_next      = bail_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cval_next      = cval_reg;
        qt_next        = qt_reg;
        cur_next       = cur_reg;
        walk_next      = walk_reg;
        endrow_next    = endrow_reg;
        endmode_next   = endmode_reg;
        ch_next        = ch_reg;
        tfirst_next    = tfirst_reg;
        t1_next        = t1_reg;
        sel_next       = sel_reg;
        v1_next        = v1_reg;
        diff_next      = diff_reg;
        phi_next       = phi_reg;
        plo_next       = plo_reg;
        out_valid_next = out_valid_reg;
        out_ch_next    = out_ch_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        out_last_next  = out_last_reg;
        t_we           = 1'b0;
        v_we           = 1'b0;
        t_addr         = walk_reg;
        v_addr         = {walk_reg, ch_reg};
        div_start      = 1'b0;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ROW_COUNT:     rowcnt_next = cfg.data;
                CFG_CHANNEL_COUNT: chcnt_next  = cfg.data[CHCNT_W-1:0];
                CFG_LINEAR_MODE:   linear_next = cfg.data[0];
                CFG_PAD_ZEROES:    pad_next    = cfg.data[0];
                CFG_BAILOUT_MODE:  bail_next   = cfg.data[1:0];
                default:           ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    row_next  = item.row_index;
                    col_next  = item.column_index;
                    cval_next = item.cell_value;
                    qt_next   = item.query_time;
                    if (item.kind == KIND_QUERY)
                        state_next = S_Q0;
                    else if (item.column_index > COL_W'(MAX_CHANNELS))
                    begin
                        out_valid_next = 1'b1;
                        out_ch_next    = '0;
                        out_val_next   = '0;
                        out_st_next    = ST_BAD_INDEX;
                        out_last_next  = 1'b1;
                        state_next     = S_OUT;
                    end
                    else if (item.column_index == '0)
                        state_next = S_LPREV;
                    else
                        state_next = S_LWR;
                end
            end
            S_LPREV:
            begin
                t_addr     = row_reg - ROW_W'(1);
                state_next = S_LCHK;
            end
            S_LCHK:
            begin
                // time written regardless; flagged when not above the row before
                t_we           = 1'b1;
                t_addr         = row_reg;
                out_valid_next = 1'b1;
                out_ch_next    = '0;
                out_val_next   = '0;
                out_st_next    = (row_reg != '0 && cval_reg <= trd) ? ST_NOT_INC : ST_OK;
                out_last_next  = 1'b1;
                state_next     = S_OUT;
            end
            S_LWR:
            begin
                v_we           = 1'b1;
                v_addr         = {row_reg, CH_W'(col_reg - COL_W'(1))};
                out_valid_next = 1'b1;
                out_ch_next    = '0;
                out_val_next   = '0;
                out_st_next    = ST_OK;
                out_last_next  = 1'b1;
                state_next     = S_OUT;
            end
            S_Q0:
            begin
                t_addr     = '0;
                state_next = S_Q1;
            end
            S_Q1:
            begin
                tfirst_next = trd;
                t_addr      = last_row;
                state_next  = S_Q2;
            end
            S_Q2:
            begin
                ch_next = '0;
                if (below || qt_reg >= trd)
                begin
                    endmode_next = 1'b1;
                    endrow_next  = below ? '0 : last_row;
                    if ((below && halt_lo) || (!below && halt_hi))
                    begin
                        out_valid_next = 1'b1;
                        out_ch_next    = '0;
                        out_val_next   = '0;
                        out_st_next    = below ? ST_HALT_BELOW : ST_HALT_ABOVE;
                        out_last_next  = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                        state_next = S_ERD;
                end
                else
                begin
                    endmode_next = 1'b0;
                    walk_next    = (cur_reg > top_row) ? top_row : cur_reg;
                    state_next   = S_DN_RD;
                end
            end
            S_ERD:
            begin
                v_addr     = {endrow_reg, ch_reg};
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                out_valid_next = 1'b1;
                out_ch_next    = COL_W'(ch_reg) + COL_W'(1);
                out_val_next   = pad_reg ? '0 : $signed(v_rdata);
                out_st_next    = ST_OK;
                out_last_next  = last_ch;
                state_next     = S_OUT;
            end
            S_DN_RD:
            begin
                t_addr     = walk_reg;
                state_next = S_DN;
            end
            S_DN:
            begin
                if (walk_reg != '0 && trd > qt_reg)
                begin
                    walk_next  = walk_reg - ROW_W'(1);
                    state_next = S_DN_RD;
                end
                else
                    state_next = S_UP_RD;
            end
            S_UP_RD:
            begin
                t_addr     = walk_reg + ROW_W'(1);
                state_next = S_UP;
            end
            S_UP:
            begin
                if (walk_reg < top_row && trd <= qt_reg)
                begin
                    walk_next  = walk_reg + ROW_W'(1);
                    state_next = S_UP_RD;
                end
                else
                begin
                    cur_next   = walk_reg;
                    state_next = S_T1;
                end
            end
            S_T1:
            begin
                t_addr     = walk_reg;
                state_next = S_T2;
            end
            S_T2:
            begin
                t1_next    = trd;
                t_addr     = walk_reg + ROW_W'(1);
                state_next = S_T3;
            end
            S_T3:
            begin
                if (!linear_reg || dt <= DT_W'(0) || at <= DT_W'(0))
                begin
                    sel_next   = SEL_V1;
                    state_next = S_V1RD;
                end
                else if (at >= dt)
                begin
                    sel_next   = SEL_V2;
                    state_next = S_V1RD;
                end
                else
                begin
                    sel_next   = SEL_LERP;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_V1RD;
            end
            S_V1RD:
            begin
                v_addr     = {walk_reg, ch_reg};
                state_next = S_V2RD;
            end
            S_V2RD:
            begin
                v1_next = $signed(v_rdata);
                v_addr  = {walk_reg + ROW_W'(1), ch_reg};
                if (sel_reg == SEL_V1)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = COL_W'(ch_reg) + COL_W'(1);
                    out_val_next   = $signed(v_rdata);
                    out_st_next    = ST_OK;
                    out_last_next  = last_ch;
                    state_next     = S_OUT;
                end
                else
                    state_next = S_MA;
            end
            S_MA:
            begin
                diff_next = DIFF_W'($signed(v_rdata)) - DIFF_W'(v1_reg);
                if (sel_reg == SEL_V2)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = COL_W'(ch_reg) + COL_W'(1);
                    out_val_next   = $signed(v_rdata);
                    out_st_next    = ST_OK;
                    out_last_next  = last_ch;
                    state_next     = S_OUT;
                end
                else
                    state_next = S_MB;
            end
            S_MB:
            begin
                phi_next   = prod;
                state_next = S_MC;
            end
            S_MC:
            begin
                plo_next   = prod;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                out_valid_next = 1'b1;
                out_ch_next    = COL_W'(ch_reg) + COL_W'(1);
                out_val_next   = res_sat;
                out_st_next    = ST_OK;
                out_last_next  = last_ch;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (result.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = endmode_reg ? S_ERD : S_V1RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rowcnt_reg    <= ROWCNT_W'(1);
            chcnt_reg     <= CHCNT_W'(1);
            linear_reg    <= 1'b1;
            pad_reg       <= 1'b1;
            bail_reg      <= 2'b00;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            endmode_reg   <= 1'b0;
            ch_reg        <= '0;
            sel_reg       <= SEL_V1;
        end
        else
        begin
            state_reg     <= state_next;
            rowcnt_reg    <= rowcnt_next;
            chcnt_reg     <= chcnt_next;
            linear_reg    <= linear_next;
            pad_reg       <= pad_next;
            bail_reg      <= bail_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            endmode_reg   <= endmode_next;
            ch_reg        <= ch_next;
            sel_reg       <= sel_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        cval_reg     <= cval_next;
        qt_reg       <= qt_next;
        walk_reg     <= walk_next;
        endrow_reg   <= endrow_next;
        tfirst_reg   <= tfirst_next;
        t1_reg       <= t1_next;
        v1_reg       <= v1_next;
        diff_reg     <= diff_next;
        phi_reg      <= phi_next;
        plo_reg      <= plo_next;
        out_ch_reg   <= out_ch_next;
        out_val_reg  <= out_val_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
    end

    // ---------------- ports
    assign cfg.ready             = 1'b1;
    assign item.ready            = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.channel_number = out_ch_reg;
    assign result.channel_value  = out_val_reg;
    assign result.status         = out_st_reg;
    assign result.last_of_run    = out_last_reg;

    // ---------------- assertions
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !result.valid)
        else $error("input taken while a result word is pending");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last_of_run) |=> item.ready)
        else $error("not ready after the final result word");

    a_div_only_lerp: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_DIV))
        else $error("divider running outside the divide step");

    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= ROW_W'(MAX_ROWS - 2))
        else $error("remembered row beyond table");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
    import tti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one input word as driven on the item channel
    typedef struct {
        logic                     kind;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic signed [TIME_W-1:0] cdata;
        logic signed [TIME_W-1:0] qtime;
    } in_word_t;

    // one result word
    typedef struct {
        logic [COL_W-1:0]        chan;
        logic signed [VAL_W-1:0] value;
        logic [STAT_W-1:0]       status;
        logic                    last;
    } out_word_t;

    // directed row: optional hand-typed single result
    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t res;
    } script_row_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam logic signed [TIME_W-1:0] T_MIN1 = 48'sh8000_0000_0001;
    localparam logic signed [TIME_W-1:0] T_MIN  = 48'sh8000_0000_0000;
    localparam logic signed [TIME_W-1:0] T_MAX  = 48'sh7FFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n;

    tti_cfg_if    cfg_if ();
    tti_item_if   item_if ();
    tti_result_if res_if ();

    time_table_interpolator_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .item   (item_if),
        .result (res_if)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Shadow of the table and registers
    // ---------------------------------------------------------------
    logic signed [TIME_W-1:0] row_time [MAX_ROWS];
    logic signed [VAL_W-1:0]  chan_val [MAX_ROWS*MAX_CHANNELS];
    int unsigned              walk_row;
    int unsigned              rows_reg, chans_reg;
    bit                       linear_reg, pad_reg;
    bit [1:0]                 bail_reg;

    out_word_t expected_words [$];
    out_word_t fresh_words [$];

    int  errors;
    int  filled_rows;   // rows 0..filled_rows-1 hold a time and every value needed
    int  send_idle_pct, recv_stall_pct;
    bit  hold_req;

    // fixed-point lerp: restoring divide for the weight, then split multiply
    function automatic logic signed [VAL_W-1:0] lerp(longint v1, longint v2, longint t1,
                                                     longint t2, longint t);
        longint          d, a, diff, phi, plo, acc;
        longint unsigned r, w;
        d = t2 - t1;
        a = t - t1;
        if (d <= 0 || a <= 0) return v1[31:0];
        if (a >= d) return v2[31:0];
        r = a;
        w = 0;
        for (int i = 0; i < 32; i++)
        begin
            r = r << 1;
            w = w << 1;
            if (r >= longint'(d))
            begin
                r = r - d;
                w = w | 1;
            end
        end
        diff = v2 - v1;
        phi  = diff * longint'(w >> 16);
        plo  = diff * longint'(w & 64'hFFFF);
        acc  = v1 + ((phi + (plo >>> 16)) >>> 16);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    function automatic void push_res(int ch, logic signed [VAL_W-1:0] v, status_t st, bit last);
        out_word_t o;
        o.chan   = ch[3:0];
        o.value  = v;
        o.status = st;
        o.last   = last;
        fresh_words.push_back(o);
    endfunction

    // works out the result words of one accepted word and updates the shadow
    function automatic void predict_word(in_word_t w);
        status_t                  st;
        int unsigned              n, nch, endrow, cur;
        logic signed [TIME_W-1:0] tf, tl;
        bit                       below;
        logic signed [VAL_W-1:0]  v;
        fresh_words.delete();
        if (w.kind == KIND_LOAD)
        begin
            st = ST_OK;
            if (w.col > MAX_CHANNELS)
                st = ST_BAD_INDEX;
            else if (w.col == 0)
            begin
                if (w.row > 0 && w.cdata <= row_time[w.row-1]) st = ST_NOT_INC;
                row_time[w.row] = w.cdata;
            end
            else
                chan_val[w.row*MAX_CHANNELS + w.col - 1] = w.cdata[31:0];
            push_res(0, '0, st, 1'b1);
            return;
        end
        n   = (rows_reg < 1) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        nch = (chans_reg < 1) ? 1 : (chans_reg > MAX_CHANNELS) ? MAX_CHANNELS : chans_reg;
        tf  = row_time[0];
        tl  = row_time[n-1];
        if (w.qtime <= tf || w.qtime >= tl)
        begin
            below  = (w.qtime <= tf);
            endrow = below ? 0 : n - 1;
            if (below && w.qtime < tf && bail_reg[0])
                push_res(0, '0, ST_HALT_BELOW, 1'b1);
            else if (!below && w.qtime > tl && bail_reg[1])
                push_res(0, '0, ST_HALT_ABOVE, 1'b1);
            else
                for (int c = 0; c < nch; c++)
                    push_res(c + 1, pad_reg ? '0 : chan_val[endrow*MAX_CHANNELS + c], ST_OK,
                             c + 1 == nch);
            return;
        end
        cur = walk_row;
        if (cur > n - 2) cur = n - 2;
        while (cur > 0 && row_time[cur] > w.qtime) cur--;
        while (cur < n - 2 && row_time[cur+1] <= w.qtime) cur++;
        walk_row = cur;
        for (int c = 0; c < nch; c++)
        begin
            v = chan_val[cur*MAX_CHANNELS + c];
            if (linear_reg)
                v = lerp(longint'(v), longint'(chan_val[(cur+1)*MAX_CHANNELS + c]),
                         longint'(row_time[cur]), longint'(row_time[cur+1]),
                         longint'(w.qtime));
            push_res(c + 1, v, ST_OK, c + 1 == nch);
        end
    endfunction

    // ---------------------------------------------------------------
    // Result side: ready with random stalls, long hold-off on request
    // ---------------------------------------------------------------
    int hold_left;

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // scoreboard: each taken result word against the oldest expectation
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", res_if.channel_value, 0);
            else
            begin
                e = expected_words.pop_front();
                if (res_if.channel_number != e.chan)
                    report_mismatch("channel_number", res_if.channel_number, e.chan);
                if (res_if.channel_value != e.value)
                    report_mismatch("channel_value", res_if.channel_value, e.value);
                if (res_if.status != e.status)
                    report_mismatch("status", res_if.status, e.status);
                if (res_if.last_of_run != e.last)
                    report_mismatch("last_of_run", res_if.last_of_run, e.last);
            end
        end
    end

    // watchdog: cycles in a row with no handshake on any channel
    int quiet_cycles;

    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else if (++quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // drives one word; valid stays high into the next word unless a gap is drawn
    task automatic send_word(in_word_t w, bit typed = 1'b0, out_word_t res = '{default: '0});
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid        <= 1'b1;
        item_if.kind         <= w.kind;
        item_if.row_index    <= w.row;
        item_if.column_index <= w.col;
        item_if.cell_value   <= w.cdata;
        item_if.query_time   <= w.qtime;
        do @(posedge clk); while (!item_if.ready);
        predict_word(w);
        if (typed)
            expected_words.push_back(res);
        else
            foreach (fresh_words[i]) expected_words.push_back(fresh_words[i]);
    endtask

    // sender stops until every expected word has come back
    task automatic drain();
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, int data);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data[CDATA_W-1:0];
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            CFG_ROW_COUNT:     rows_reg   = data & 32'h7FF;
            CFG_CHANNEL_COUNT: chans_reg  = data & 32'hF;
            CFG_LINEAR_MODE:   linear_reg = data[0];
            CFG_PAD_ZEROES:    pad_reg    = data[0];
            CFG_BAILOUT_MODE:  bail_reg   = data[1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic configure(int rows, int chans, int lin, int pad, int bail);
        write_reg(CFG_ROW_COUNT, rows);
        write_reg(CFG_CHANNEL_COUNT, chans);
        write_reg(CFG_LINEAR_MODE, lin);
        write_reg(CFG_PAD_ZEROES, pad);
        write_reg(CFG_BAILOUT_MODE, bail);
    endtask

    // loads rows in order with rising times, so every earlier row is written first
    task automatic fill_table(int rows, int chans, longint start);
        in_word_t w;
        longint   t;
        t = start;
        w.kind  = KIND_LOAD;
        w.qtime = '0;
        for (int r = 0; r < rows; r++)
        begin
            w.row   = r[ROW_W-1:0];
            w.col   = '0;
            w.cdata = t[TIME_W-1:0];
            send_word(w);
            for (int c = 1; c <= chans; c++)
            begin
                w.col   = c[COL_W-1:0];
                w.cdata = TIME_W'({$urandom, $urandom});
                send_word(w);
            end
            t += $urandom_range(1, 1 << 20);
        end
        if (rows > filled_rows) filled_rows = rows;
    endtask

    // random word: mostly queries near the row times, loads confined to filled rows
    task automatic random_word(output in_word_t w);
        int unsigned n, r, sel;
        n = (rows_reg < 1) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        w.cdata = TIME_W'({$urandom, $urandom});
        w.qtime = TIME_W'({$urandom, $urandom});
        w.row   = ROW_W'($urandom_range(0, filled_rows - 1));
        w.col   = COL_W'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0)
        begin
            w.kind = KIND_LOAD;
            // nudge a time by a few ulps: sometimes not increasing
            if (w.col == 0)
                w.cdata = row_time[w.row] + TIME_W'($signed($urandom_range(0, 6)) - 3);
        end
        else
        begin
            w.kind = KIND_QUERY;
            r   = $urandom_range(0, n - 1);
            sel = $urandom_range(0, 9);
            if (sel < 2)
                w.qtime = row_time[r];
            else if (sel < 6)
                w.qtime = row_time[r] + TIME_W'($urandom_range(0, 1 << 20));
            else if (sel < 8)
                w.qtime = row_time[r] - TIME_W'($urandom_range(0, 1 << 20));
        end
    endtask

    task automatic random_phase(int count, int hold_at, int pause_at);
        in_word_t w;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at) hold_req = 1'b1;
            if (i == pause_at) drain();
            random_word(w);
            send_word(w);
        end
        drain();
    endtask

    // ---------------------------------------------------------------
    // Directed words: ends of the fields, every load status, ends of the table
    // ---------------------------------------------------------------
    script_row_t script [] = '{
        '{'{KIND_LOAD, 10'd0, 4'd0, T_MIN1, '0}, 1'b1, '{4'd0, 32'sd0, ST_OK, 1'b1}},
        '{'{KIND_LOAD, 10'd1, 4'd0, 48'sd0, '0}, 1'b1, '{4'd0, 32'sd0, ST_OK, 1'b1}},
        '{'{KIND_LOAD, 10'd2, 4'd0, 48'sh1_0000, '0}, 1'b1, '{4'd0, 32'sd0, ST_OK, 1'b1}},
        '{'{KIND_LOAD, 10'd3, 4'd0, T_MAX, '0}, 1'b1, '{4'd0, 32'sd0, ST_OK, 1'b1}},
        // same time as the row before: flagged but still written
        '{'{KIND_LOAD, 10'd2, 4'd0, 48'sd0, '0}, 1'b1, '{4'd0, 32'sd0, ST_NOT_INC, 1'b1}},
        '{'{KIND_LOAD, 10'd2, 4'd0, 48'sh1_0000, '0}, 1'b1, '{4'd0, 32'sd0, ST_OK, 1'b1}},
        '{'{KIND_LOAD, 10'd1, 4'd1, 48'shFFFF_7FFF_FFFF, '0}, 1'b1,
          '{4'd0, 32'sd0, ST_OK, 1'b1}},
        '{'{KIND_LOAD, 10'd2, 4'd1, 48'sh0000_8000_0000, '0}, 1'b1,
          '{4'd0, 32'sd0, ST_OK, 1'b1}},
        '{'{KIND_LOAD, 10'd0, 4'd8, 48'sh1234_8000_0001, '0}, 1'b1,
          '{4'd0, 32'sd0, ST_OK, 1'b1}},
        // column beyond the channels: nothing written
        '{'{KIND_LOAD, 10'd3, 4'd9, T_MAX, '0}, 1'b1, '{4'd0, 32'sd0, ST_BAD_INDEX, 1'b1}},
        '{'{KIND_LOAD, 10'd0, 4'd15, T_MIN, '0}, 1'b1, '{4'd0, 32'sd0, ST_BAD_INDEX, 1'b1}},
        '{'{KIND_QUERY, '0, '0, '0, T_MIN}, 1'b0, '{default: '0}},
        '{'{KIND_QUERY, '0, '0, '0, T_MIN1}, 1'b0, '{default: '0}},
        '{'{KIND_QUERY, '0, '0, '0, T_MAX}, 1'b0, '{default: '0}},
        '{'{KIND_QUERY, '0, '0, '0, -48'sd1}, 1'b0, '{default: '0}},
        '{'{KIND_QUERY, '0, '0, '0, 48'sd0}, 1'b0, '{default: '0}},
        '{'{KIND_QUERY, '0, '0, '0, 48'sh8000}, 1'b0, '{default: '0}},
        '{'{KIND_QUERY, '0, '0, '0, 48'shFFFF}, 1'b0, '{default: '0}},
        '{'{KIND_QUERY, '0, '0, '0, 48'sh1_0000}, 1'b0, '{default: '0}},
        '{'{KIND_QUERY, '0, '0, '0, 48'sh4000_0000_0000}, 1'b0, '{default: '0}},
        '{'{KIND_QUERY, '0, '0, '0, T_MAX - 48'sd1}, 1'b0, '{default: '0}}
    };

    initial
    begin
        errors         = 0;
        filled_rows    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        quiet_cycles   = 0;
        walk_row       = 0;
        rows_reg       = 1;
        chans_reg      = 1;
        linear_reg     = 1'b1;
        pad_reg        = 1'b1;
        bail_reg       = 2'd0;

        rst_n                = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        item_if.valid        = 1'b0;
        item_if.kind         = KIND_LOAD;
        item_if.row_index    = '0;
        item_if.column_index = '0;
        item_if.cell_value   = '0;
        item_if.query_time   = '0;
        res_if.ready         = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // four rows of two channels, then the directed words with no idling
        configure(4, 2, 1, 1, 0);
        fill_table(4, 2, 0);
        foreach (script[i]) send_word(script[i].w, script[i].typed, script[i].res);
        drain();
        // same table, end row repeated instead of zeros
        write_reg(CFG_PAD_ZEROES, 0);
        foreach (script[i])
            if (script[i].w.kind == KIND_QUERY) send_word(script[i].w);
        drain();

        // halts both sides, sender gaps
        send_idle_pct = 68;
        configure(5, 3, 1, 0, 3);
        fill_table(5, 8, -(64'sd1 << 24));
        random_phase(20, -1, -1);

        // row and channel counts of zero act as one; receiver stalls
        send_idle_pct  = 0;
        recv_stall_pct = 68;
        configure(0, 0, 0, 1, 1);
        random_phase(10, -1, -1);

        // channel count above the top saturates; both sides idle, long receiver hold-off
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        configure(5, 15, 0, 0, 2);
        random_phase(20, 5, -1);

        // two rows only, all channels; sender waits for the block to empty midway
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(2, 8, 1, 0, 0);
        random_phase(20, -1, 10);

        // one channel, both sides idle
        configure(5, 1, 1, 1, 0);
        send_idle_pct  = 68;
        recv_stall_pct = 68;
        random_phase(15, -1, -1);

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
